// ===== hdl/pps_pkg.sv =====
// Shared types and constants for the pure-pursuit steering block.
package pps_pkg;

  typedef enum logic [1:0] {
    ACT_CLEAR  = 2'd0,
    ACT_APPEND = 2'd1,
    ACT_POSE   = 2'd2,
    ACT_NONE   = 2'd3
  } action_e;

  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_LOOK_AHEAD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GOAL_TOL   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_SPEED  = 2'd2;

  localparam logic [30:0] LOOK_AHEAD_RST = 31'd32768;
  localparam logic [30:0] GOAL_TOL_RST   = 31'd6554;
  localparam logic [30:0] MAX_SPEED_RST  = 31'd19661;

  localparam int unsigned TRIG_BITS = 14;

  typedef struct packed {
    logic [1:0]         action;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [15:0] heading_cos;
    logic signed [15:0] heading_sin;
  } in_item_t;

  typedef struct packed {
    logic               goal_reached;
    logic               path_empty;
    logic signed [31:0] linear_cmd;
    logic signed [31:0] angular_cmd;
    logic signed [31:0] carrot_x;
    logic signed [31:0] carrot_y;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic load;     // capture input item
    logic clr;      // clear path
    logic app;      // append waypoint
    logic rd;       // issue memory read at index
    logic scan;     // evaluate read entry against look-ahead
    logic sel_fin;  // compute carrot rotation / goal for selected entry
    logic rot2;     // second rotation step
    logic d2;       // compute d^2
    logic div_go;   // start divider
    logic finish;   // build result
    logic empty;    // build empty result
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [1:0] action;
    logic       path_empty;
    logic       last;     // index is last stored entry
    logic       hit;      // entry at or beyond look-ahead
    logic       no_div;   // goal reached or d^2 at or below threshold
    logic       div_done;
  } sts_t;

endpackage

// ===== hdl/pps_div.sv =====
// Restoring serial divider: floor((m << FRAC) / d), capped at 2^32.
module pps_div #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] num_i,
  input  logic [63:0] den_i,
  output logic        done_o,
  output logic [32:0] quo_o
);
  localparam int unsigned STEPS = 64 + FRAC_BITS;
  localparam int unsigned CW    = $clog2(STEPS + 1);

  logic [STEPS-1:0] sh_q, sh_d;
  logic [64:0]      r_q, r_d;
  logic [32:0]      q_q, q_d;
  logic [63:0]      den_q;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             busy_q, busy_d, done_q, done_d;
  logic [64:0]      rs;
  logic [33:0]      qs;

  always_comb begin
    sh_d = sh_q; r_d = r_q; q_d = q_q; cnt_d = cnt_q;
    busy_d = busy_q; done_d = 1'b0;
    rs = '0; qs = '0;
    if (start_i) begin
      sh_d   = {num_i, {FRAC_BITS{1'b0}}};
      r_d    = '0;
      q_d    = '0;
      cnt_d  = CW'(STEPS);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rs = {r_q[63:0], sh_q[STEPS-1]};
      qs = {q_q, 1'b0};
      if (rs >= {1'b0, den_q}) begin
        rs = rs - {1'b0, den_q};
        qs[0] = 1'b1;
      end
      if (qs > 34'hFFFF_FFFF) qs = 34'h1_0000_0000;
      r_d   = rs;
      q_d   = qs[32:0];
      sh_d  = {sh_q[STEPS-2:0], 1'b0};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sh_q <= sh_d;
    r_q  <= r_d;
    q_q  <= q_d;
    if (start_i) den_q <= den_i;
  end

  assign done_o = done_q;
  assign quo_o  = q_q;
endmodule

// ===== hdl/pps_datapath.sv =====
// Datapath: waypoint memory, distance checks, rotation and command build.
module pps_datapath #(
  parameter int unsigned PATH_DEPTH = 256,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  pps_pkg::in_item_t in_i,
  input  pps_pkg::cmd_t    cmd_i,
  input  logic             cfg_we_i,
  input  logic [1:0]       cfg_idx_i,
  input  logic [30:0]      cfg_data_i,
  output pps_pkg::sts_t    sts_o,
  output pps_pkg::out_item_t res_o
);
  import pps_pkg::*;

  localparam int unsigned AW = (PATH_DEPTH > 1) ? $clog2(PATH_DEPTH) : 1;
  localparam int unsigned NW = $clog2(PATH_DEPTH + 1);
  localparam logic [63:0] THR = 64'((64'd1 << (2 * FRAC_BITS)) / 1000);

  logic [31:0] mem_x [PATH_DEPTH];
  logic [31:0] mem_y [PATH_DEPTH];
  logic [31:0] rx_q, ry_q;
  logic [NW-1:0] cnt_q;
  logic [AW-1:0] idx_q, sel_q;
  logic [30:0] la_q, gt_q, ms_q;
  in_item_t    it_q;

  logic signed [32:0] dx_q, dy_q;
  logic [63:0] lim_la_q, lim_gt_q;
  logic hit_q, goal_q;
  logic signed [63:0] p1_q, p2_q, p3_q, p4_q;
  logic signed [31:0] cx_q, cy_q;
  logic [63:0] d2_q, num_q;
  logic no_div_q;
  out_item_t res_q;

  logic        dv_done;
  logic [32:0] quo;

  // squared-sum with saturation
  function automatic logic [63:0] sqs(input logic signed [32:0] a,
                                      input logic signed [32:0] b);
    logic [32:0] ma, mb;
    logic [64:0] s;
    begin
      ma = a[32] ? 33'(-a) : 33'(a);
      mb = b[32] ? 33'(-b) : 33'(b);
      s  = 65'(ma * ma) + 65'(mb * mb);
      sqs = s[64] ? 64'hFFFF_FFFF_FFFF_FFFF : s[63:0];
    end
  endfunction

  function automatic logic signed [31:0] rsat(input logic signed [63:0] v);
    logic signed [63:0] f;
    begin
      f = v >>> TRIG_BITS;
      if (f > 64'sh7FFF_FFFF) rsat = 32'sh7FFF_FFFF;
      else if (f < -64'sh8000_0000) rsat = 32'sh8000_0000;
      else rsat = f[31:0];
    end
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      la_q  <= LOOK_AHEAD_RST;
      gt_q  <= GOAL_TOL_RST;
      ms_q  <= MAX_SPEED_RST;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_LOOK_AHEAD: la_q <= cfg_data_i;
          REG_GOAL_TOL:   gt_q <= cfg_data_i;
          REG_MAX_SPEED:  ms_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.clr) cnt_q <= '0;
      else if (cmd_i.app && cnt_q < NW'(PATH_DEPTH)) cnt_q <= cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.app && cnt_q < NW'(PATH_DEPTH)) begin
      mem_x[cnt_q[AW-1:0]] <= it_q.pos_x;
      mem_y[cnt_q[AW-1:0]] <= it_q.pos_y;
    end
    if (cmd_i.rd) begin
      rx_q <= mem_x[idx_q];
      ry_q <= mem_y[idx_q];
    end
  end

  logic [AW-1:0] last_idx;
  assign last_idx = AW'(cnt_q - 1'b1);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      it_q     <= in_i;
      idx_q    <= '0;
      lim_la_q <= 64'(la_q) * 64'(la_q);
      lim_gt_q <= 64'(gt_q) * 64'(gt_q);
    end
    if (cmd_i.scan) begin
      hit_q <= sqs(33'(signed'(rx_q)) - 33'(it_q.pos_x),
                   33'(signed'(ry_q)) - 33'(it_q.pos_y)) >= lim_la_q;
      dx_q  <= 33'(signed'(rx_q)) - 33'(it_q.pos_x);
      dy_q  <= 33'(signed'(ry_q)) - 33'(it_q.pos_y);
      sel_q <= idx_q;
      if (idx_q != last_idx) idx_q <= idx_q + 1'b1;
    end
    if (cmd_i.sel_fin) begin
      goal_q <= sqs(dx_q, dy_q) <= lim_gt_q;
      p1_q <= 64'(dx_q) * 64'(it_q.heading_cos);
      p2_q <= 64'(dy_q) * 64'(it_q.heading_sin);
      p3_q <= 64'(dy_q) * 64'(it_q.heading_cos);
      p4_q <= 64'(dx_q) * 64'(it_q.heading_sin);
    end
    if (cmd_i.rot2) begin
      cx_q <= rsat(p1_q + p2_q);
      cy_q <= rsat(p3_q - p4_q);
    end
    if (cmd_i.d2) begin
      d2_q     <= sqs(33'(cx_q), 33'(cy_q));
      num_q    <= 64'({1'b0, (cy_q[31] ? 32'(-cy_q) : 32'(cy_q))} * {ms_q, 1'b0});
      no_div_q <= goal_q || (sqs(33'(cx_q), 33'(cy_q)) <= THR);
    end
    if (cmd_i.empty) begin
      res_q.goal_reached <= 1'b0;
      res_q.path_empty   <= 1'b1;
      res_q.linear_cmd   <= '0;
      res_q.angular_cmd  <= '0;
      res_q.carrot_x     <= '0;
      res_q.carrot_y     <= '0;
    end
    if (cmd_i.finish) begin
      res_q.goal_reached <= goal_q;
      res_q.path_empty   <= 1'b0;
      res_q.carrot_x     <= cx_q;
      res_q.carrot_y     <= cy_q;
      res_q.linear_cmd   <= goal_q ? 32'sd0 : 32'({1'b0, ms_q});
      if (no_div_q) res_q.angular_cmd <= '0;
      else if (cy_q[31])
        res_q.angular_cmd <= (quo > 33'h0_8000_0000) ? 32'sh8000_0000 : 32'(-quo);
      else
        res_q.angular_cmd <= (quo > 33'h0_7FFF_FFFF) ? 32'sh7FFF_FFFF : quo[31:0];
    end
  end

  pps_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk_i, .rst_ni,
    .start_i(cmd_i.div_go), .num_i(num_q), .den_i(d2_q),
    .done_o(dv_done), .quo_o(quo)
  );

  assign sts_o.action     = it_q.action;
  assign sts_o.path_empty = (cnt_q == '0);
  assign sts_o.last       = (sel_q == last_idx);
  assign sts_o.hit        = hit_q;
  assign sts_o.no_div     = no_div_q;
  assign sts_o.div_done   = dv_done;
  assign res_o            = res_q;
endmodule

// ===== hdl/pps_ctrl.sv =====
// Controller: sequences clear, append and pose computation.
module pps_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  input  pps_pkg::sts_t sts_i,
  output pps_pkg::cmd_t cmd_o
);
  import pps_pkg::*;

  typedef enum logic [10:0] {
    S_IDLE = 11'b000_0000_0001,
    S_DEC  = 11'b000_0000_0010,
    S_RD   = 11'b000_0000_0100,
    S_WAIT = 11'b000_0000_1000,
    S_SCAN = 11'b000_0001_0000,
    S_CHK  = 11'b000_0010_0000,
    S_ROT  = 11'b000_0100_0000,
    S_ROT2 = 11'b000_1000_0000,
    S_D2   = 11'b001_0000_0000,
    S_DIV  = 11'b010_0000_0000,
    S_FIN  = 11'b100_0000_0000
  } state_e;

  state_e st_q, st_d;
  logic   ov_q, ov_d;

  always_comb begin
    st_d = st_q;
    ov_d = ov_q;
    cmd_o = '0;
    if (ov_q && out_ready_i) ov_d = 1'b0;
    case (st_q)
      S_IDLE: if (in_valid_i) begin
        cmd_o.load = 1'b1;
        st_d = S_DEC;
      end
      S_DEC: begin
        case (sts_i.action)
          ACT_CLEAR:  begin cmd_o.clr = 1'b1; st_d = S_IDLE; end
          ACT_APPEND: begin cmd_o.app = 1'b1; st_d = S_IDLE; end
          ACT_POSE:   begin
            if (sts_i.path_empty) begin
              if (!ov_q) begin
                cmd_o.empty = 1'b1; ov_d = 1'b1; st_d = S_IDLE;
              end
            end else st_d = S_RD;
          end
          default: st_d = S_IDLE;
        endcase
      end
      S_RD:   begin cmd_o.rd = 1'b1; st_d = S_WAIT; end
      S_WAIT: begin cmd_o.scan = 1'b1; st_d = S_CHK; end
      S_SCAN: st_d = S_RD;
      S_CHK:  st_d = (sts_i.hit || sts_i.last) ? S_ROT : S_RD;
      S_ROT:  begin cmd_o.sel_fin = 1'b1; st_d = S_ROT2; end
      S_ROT2: begin cmd_o.rot2 = 1'b1; st_d = S_D2; end
      S_D2:   begin cmd_o.d2 = 1'b1; st_d = S_DIV; end
      S_DIV:  begin
        if (sts_i.no_div) st_d = S_FIN;
        else begin cmd_o.div_go = 1'b1; st_d = S_SCAN; end
      end
      S_FIN:  if (!ov_q) begin
        cmd_o.finish = 1'b1; ov_d = 1'b1; st_d = S_IDLE;
      end
      default: st_d = S_IDLE;
    endcase
    // divider wait reuses S_SCAN slot
    if (st_q == S_SCAN) st_d = sts_i.div_done ? S_FIN : S_SCAN;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE;
      ov_q <= 1'b0;
    end else begin
      st_q <= st_d;
      ov_q <= ov_d;
    end
  end

  assign in_ready_o  = (st_q == S_IDLE);
  assign out_valid_o = ov_q;
endmodule

// ===== hdl/pure_pursuit_steering.sv =====
// Top level of the pure-pursuit steering block.
// Clear and append end after decode. A pose reads and checks waypoints in order
// (memory read, compare), then rotates, forms d^2, runs the serial divider
// if needed. One item at a time; the result register lets the next item start
// while a result waits. Reset empties the path and loads register defaults.
module pure_pursuit_steering #(
  parameter int unsigned PATH_DEPTH = 256,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  pps_pkg::in_item_t   in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output pps_pkg::out_item_t  out_data_o,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_idx_i,
  input  logic [30:0]         cfg_data_i
);
  import pps_pkg::*;

  cmd_t cmd;
  sts_t sts;

  pps_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
    .sts_i(sts), .cmd_o(cmd)
  );

  pps_datapath #(.PATH_DEPTH(PATH_DEPTH), .FRAC_BITS(FRAC_BITS)) u_dp (
    .clk_i, .rst_ni, .in_i(in_data_i), .cmd_i(cmd),
    .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .sts_o(sts), .res_o(out_data_o)
  );
endmodule

// ===== sim/pure_pursuit_steering_tb.sv =====
// Self-checking testbench for pure_pursuit_steering: directed and random path/pose traffic.
`timescale 1ns / 1ps

module pure_pursuit_steering_tb;
  import pps_pkg::*;

  localparam int unsigned DEPTH     = 256;
  localparam int unsigned WD_LIMIT  = 20000;
  localparam logic [63:0] CURV_THR  = 64'd4294967;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_ready_o;
  in_item_t  in_data_i = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  out_item_t out_data_o;
  logic      cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = '0;
  logic [30:0] cfg_data_i = '0;

  pure_pursuit_steering uut (.*);

  always #4 clk_i = ~clk_i;

  // predictor state
  logic signed [31:0] path_x [DEPTH];
  logic signed [31:0] path_y [DEPTH];
  int unsigned        path_len;
  logic [30:0]        la_reg, tol_reg, speed_reg;
  out_item_t          steer_q [$];

  int  err_cnt = 0;
  int  ready_pct = 70;
  bit  hold_req = 1'b0;
  bit  no_gaps = 1'b0;
  int  stall_left = 0;
  int  hold_left = 0;
  int  quiet_cnt = 0;

  function automatic logic [63:0] mag(longint v);
    return v < 0 ? 64'(-v) : 64'(v);
  endfunction

  function automatic logic [63:0] dist_sq(longint a, longint b);
    logic [63:0] p1, p2;
    logic [64:0] s;
    p1 = mag(a) * mag(a);
    p2 = mag(b) * mag(b);
    s = 65'(p1) + 65'(p2);
    return s[64] ? '1 : s[63:0];
  endfunction

  function automatic longint sat32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic bit predict_steering(in_item_t it, output out_item_t res);
    longint px, py, hc, hs, dx, dy, cx, cy, ang;
    logic [63:0] la2, tol2, d2;
    logic [127:0] num, q;
    int unsigned sel;
    bit goal;
    res = '0;
    px = it.pos_x; py = it.pos_y; hc = it.heading_cos; hs = it.heading_sin;
    case (action_e'(it.action))
      ACT_CLEAR: begin path_len = 0; return 0; end
      ACT_APPEND: begin
        if (path_len < DEPTH) begin
          path_x[path_len] = it.pos_x;
          path_y[path_len] = it.pos_y;
          path_len++;
        end
        return 0;
      end
      ACT_POSE: ;
      default: return 0;
    endcase
    if (path_len == 0) begin
      res.path_empty = 1'b1;
      return 1;
    end
    la2 = 64'(la_reg) * 64'(la_reg);
    tol2 = 64'(tol_reg) * 64'(tol_reg);
    sel = path_len - 1;
    for (int unsigned i = 0; i < path_len; i++) begin
      if (dist_sq(longint'(path_x[i]) - px, longint'(path_y[i]) - py) >= la2) begin
        sel = i;
        break;
      end
    end
    dx = longint'(path_x[sel]) - px;
    dy = longint'(path_y[sel]) - py;
    goal = dist_sq(dx, dy) <= tol2;
    cx = sat32((dx * hc + dy * hs) >>> TRIG_BITS);
    cy = sat32((dy * hc - dx * hs) >>> TRIG_BITS);
    ang = 0;
    if (!goal) begin
      res.linear_cmd = 32'(speed_reg);
      d2 = dist_sq(cx, cy);
      if (d2 > CURV_THR) begin
        num = (128'(mag(cy)) * 128'(speed_reg) * 2) << 16;
        q = num / 128'(d2);
        if (q > 128'h1_0000_0000) q = 128'h1_0000_0000;
        if (cy < 0) ang = (q > 128'h8000_0000) ? -64'sd2147483648 : -longint'(q[32:0]);
        else ang = (q > 128'h7FFF_FFFF) ? 64'sd2147483647 : longint'(q[32:0]);
      end
    end
    res.goal_reached = goal;
    res.angular_cmd = 32'(ang);
    res.carrot_x = 32'(cx);
    res.carrot_y = 32'(cy);
    return 1;
  endfunction

  // receiver: random ready, occasional stalls, one long hold-off on request
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (hold_req) begin
        hold_req = 1'b0;
        hold_left = 500;
        out_ready_i <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else if ($urandom_range(0, 99) < 2) begin
        stall_left = $urandom_range(10, 60);
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(0, 99) < ready_pct);
      end
    end
  end

  // result checker
  always @(posedge clk_i) begin
    out_item_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (steer_q.size() == 0) begin
        $error("unexpected result transfer");
        err_cnt++;
      end else begin
        e = steer_q.pop_front();
        if (out_data_o.goal_reached !== e.goal_reached) begin
          $error("goal_reached exp %0d got %0d", e.goal_reached, out_data_o.goal_reached);
          err_cnt++;
        end
        if (out_data_o.path_empty !== e.path_empty) begin
          $error("path_empty exp %0d got %0d", e.path_empty, out_data_o.path_empty);
          err_cnt++;
        end
        if (out_data_o.linear_cmd !== e.linear_cmd) begin
          $error("linear_cmd exp %0d got %0d", e.linear_cmd, out_data_o.linear_cmd);
          err_cnt++;
        end
        if (out_data_o.angular_cmd !== e.angular_cmd) begin
          $error("angular_cmd exp %0d got %0d", e.angular_cmd, out_data_o.angular_cmd);
          err_cnt++;
        end
        if (out_data_o.carrot_x !== e.carrot_x) begin
          $error("carrot_x exp %0d got %0d", e.carrot_x, out_data_o.carrot_x);
          err_cnt++;
        end
        if (out_data_o.carrot_y !== e.carrot_y) begin
          $error("carrot_y exp %0d got %0d", e.carrot_y, out_data_o.carrot_y);
          err_cnt++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || !rst_ni) begin
      quiet_cnt <= 0;
    end else if (quiet_cnt >= WD_LIMIT) begin
      $display("pure_pursuit_steering test failed");
      $finish;
    end else begin
      quiet_cnt <= quiet_cnt + 1;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_item(in_item_t it);
    int gap;
    out_item_t res;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= it;
    do @(posedge clk_i); while (!in_ready_o);
    if (predict_steering(it, res)) steer_q.push_back(res);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (steer_q.size() != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [30:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_LOOK_AHEAD: la_reg = val;
      REG_GOAL_TOL:   tol_reg = val;
      REG_MAX_SPEED:  speed_reg = val;
      default: ;
    endcase
  endtask

  task automatic configure(logic [30:0] la, logic [30:0] tol, logic [30:0] spd);
    drain();
    write_reg(REG_LOOK_AHEAD, la);
    write_reg(REG_GOAL_TOL, tol);
    write_reg(REG_MAX_SPEED, spd);
  endtask

  function automatic in_item_t mk(action_e a, int x, int y, int c, int s);
    in_item_t it;
    it.action = a;
    it.pos_x = x;
    it.pos_y = y;
    it.heading_cos = 16'(c);
    it.heading_sin = 16'(s);
    return it;
  endfunction

  function automatic int rand_coord();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return int'($urandom_range(0, 32'h000F_FFFF)) - 32'h0008_0000;
    if (r < 90) return int'($urandom_range(0, 32'h03FF_FFFF)) - 32'h0200_0000;
    return int'($urandom);
  endfunction

  function automatic int rand_head();
    return int'($urandom_range(0, 32768)) - 16384;
  endfunction

  function automatic logic [30:0] rand_reg(int scale);
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 31'd0;
    if (r == 1) return 31'h7FFF_FFFF;
    return 31'($urandom_range(0, scale));
  endfunction

  task automatic test_empty_path();
    send_item(mk(ACT_POSE, 0, 0, 16384, 0));
    send_item(mk(ACT_POSE, 32'h7FFF_FFFF, 32'h8000_0000, -16384, 16384));
    send_item(mk(ACT_APPEND, 65536, 0, 0, 0));
    send_item(mk(ACT_CLEAR, 0, 0, 0, 0));
    send_item(mk(ACT_POSE, 100, -100, 0, 16384));
    drain();
  endtask

  task automatic test_directed();
    send_item(mk(ACT_NONE, 5, 5, 0, 0));
    send_item(mk(ACT_APPEND, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0));
    send_item(mk(ACT_APPEND, 32'h8000_0000, 32'h8000_0000, 0, 0));
    send_item(mk(ACT_APPEND, 65536, 65536, 0, 0));
    send_item(mk(ACT_POSE, 32'h8000_0000, 32'h8000_0000, 16384, 0));
    send_item(mk(ACT_POSE, 32'h7FFF_FFFF, 32'h7FFF_FFFF, -16384, 0));
    send_item(mk(ACT_POSE, 0, 0, 0, -16384));
    send_item(mk(ACT_POSE, 65536, 65536, 16384, 0));
    send_item(mk(ACT_CLEAR, 0, 0, 0, 0));
    send_item(mk(ACT_APPEND, 10, 20, 0, 0));
    send_item(mk(ACT_POSE, 0, 0, 11585, 11585));
    send_item(mk(ACT_POSE, 0, 0, 16384, 16384));
    send_item(mk(ACT_NONE, 0, 0, 0, 0));
    configure(31'd0, 31'd0, 31'h7FFF_FFFF);
    send_item(mk(ACT_POSE, 0, 0, 16384, 0));
    send_item(mk(ACT_APPEND, 0, 32'h0001_0000, 0, 0));
    send_item(mk(ACT_POSE, -65536, 0, 16384, 0));
    send_item(mk(ACT_POSE, 0, 32'h7000_0000, 16384, 0));
    configure(31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'd0);
    send_item(mk(ACT_POSE, 1000, 1000, 16384, 0));
    send_item(mk(ACT_POSE, 32'h8000_0000, 32'h7FFF_FFFF, 16384, -16384));
    configure(LOOK_AHEAD_RST, GOAL_TOL_RST, MAX_SPEED_RST);
  endtask

  task automatic test_full_path();
    send_item(mk(ACT_CLEAR, 0, 0, 0, 0));
    for (int i = 0; i < DEPTH + 4; i++)
      send_item(mk(ACT_APPEND, rand_coord(), rand_coord(), 0, 0));
    configure(31'h7FFF_FFFF, 31'd6554, 31'd19661);
    send_item(mk(ACT_POSE, rand_coord(), rand_coord(), rand_head(), rand_head()));
    send_item(mk(ACT_POSE, 0, 0, 16384, 0));
    configure(LOOK_AHEAD_RST, GOAL_TOL_RST, MAX_SPEED_RST);
    send_item(mk(ACT_CLEAR, 0, 0, 0, 0));
  endtask

  task automatic test_random(int phases, int per_phase);
    int r, x, y;
    for (int p = 0; p < phases; p++) begin
      configure(rand_reg(32'h0020_0000), rand_reg(32'h0004_0000), rand_reg(32'h0004_0000));
      ready_pct = $urandom_range(30, 100);
      no_gaps = ($urandom_range(0, 3) == 0);
      if (p == 2) hold_req = 1'b1;
      send_item(mk(ACT_CLEAR, 0, 0, 0, 0));
      for (int k = $urandom_range(1, 10); k > 0; k--)
        send_item(mk(ACT_APPEND, rand_coord(), rand_coord(), 0, 0));
      for (int n = 0; n < per_phase; n++) begin
        r = $urandom_range(0, 99);
        x = rand_coord();
        y = rand_coord();
        if (r < 4) send_item(mk(ACT_CLEAR, x, y, rand_head(), rand_head()));
        else if (r < 25) send_item(mk(ACT_APPEND, x, y, rand_head(), rand_head()));
        else if (r < 29) send_item(mk(ACT_NONE, x, y, rand_head(), rand_head()));
        else if (r < 35 && path_len > 0)
          send_item(mk(ACT_POSE, path_x[0], path_y[0], rand_head(), rand_head()));
        else send_item(mk(ACT_POSE, x, y, rand_head(), rand_head()));
      end
    end
    no_gaps = 1'b0;
    drain();
  endtask

  initial begin
    path_len = 0;
    la_reg = LOOK_AHEAD_RST;
    tol_reg = GOAL_TOL_RST;
    speed_reg = MAX_SPEED_RST;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_path();
    test_directed();
    test_full_path();
    test_random(12, 30);
    if (err_cnt == 0) begin
      $display("pure_pursuit_steering test passed");
    end else begin
      $display("pure_pursuit_steering test failed");
    end
    $finish;
  end

endmodule
